// ===== rtl/pdm_pkg.sv =====
// shared constants and event codes for the pwm duty meter
package pdm_pkg;

  localparam int unsigned NOW_BITS  = 48;
  localparam int unsigned DUTY_BITS = 10;
  localparam int unsigned CFG_BITS  = 32;
  localparam int unsigned OP_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_PWM    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ENABLE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd2;

  localparam logic [DUTY_BITS-1:0] PERMILLE_FULL = 10'd1000;
  localparam logic [CFG_BITS-1:0]  TIMEOUT_RESET = 32'd3000000;

endpackage

// ===== rtl/pdm_addmod.sv =====
// shared modular adder: a + b, reduced once by the period
module pdm_addmod #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0] a_i,
  input  logic [TIME_BITS-1:0] b_i,
  input  logic [TIME_BITS-1:0] p_i,
  output logic [TIME_BITS-1:0] sum_o,
  output logic                 carry_o
);

  logic [TIME_BITS:0] raw;
  logic [TIME_BITS:0] red;

  assign raw     = {1'b0, a_i} + {1'b0, b_i};
  assign red     = raw - {1'b0, p_i};
  assign carry_o = (raw >= {1'b0, p_i});
  assign sum_o   = carry_o ? red[TIME_BITS-1:0] : raw[TIME_BITS-1:0];

endmodule

// ===== rtl/pdm_duty_div.sv =====
// sequencer for round(1000 * high / period) over the shared modular adder
module pdm_duty_div #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [TIME_BITS-1:0]            high_i,
  input  logic [TIME_BITS-1:0]            period_i,
  output logic                            done_o,
  output logic [pdm_pkg::DUTY_BITS-1:0]   duty_o
);
  import pdm_pkg::*;

  localparam int unsigned IDX_BITS = $clog2(DUTY_BITS);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_DBL  = 2'd1;
  localparam logic [1:0] D_ADD  = 2'd2;
  localparam logic [1:0] D_RND  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [TIME_BITS-1:0] r_q, r_d;
  logic [TIME_BITS-1:0] h_q, h_d;
  logic [TIME_BITS-1:0] p_q, p_d;
  logic [DUTY_BITS-1:0] q_q, q_d;
  logic [IDX_BITS-1:0]  idx_q, idx_d;
  logic                 done_q, done_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;

  logic [TIME_BITS-1:0] unit_b;
  logic [TIME_BITS-1:0] unit_sum;
  logic                 unit_carry;
  logic [DUTY_BITS:0]   q_round;

  assign unit_b = (state_q == D_ADD) ? h_q : r_q;

  pdm_addmod #(
    .TIME_BITS(TIME_BITS)
  ) u_addmod (
    .a_i    (r_q),
    .b_i    (unit_b),
    .p_i    (p_q),
    .sum_o  (unit_sum),
    .carry_o(unit_carry)
  );

  assign q_round = {1'b0, q_q} + {{DUTY_BITS{1'b0}}, unit_carry};

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    h_d     = h_q;
    p_d     = p_q;
    q_d     = q_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    duty_d  = duty_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          r_d     = '0;
          h_d     = high_i;
          p_d     = period_i;
          q_d     = '0;
          idx_d   = IDX_BITS'(DUTY_BITS - 1);
          state_d = D_DBL;
        end
      end
      D_DBL: begin
        r_d = unit_sum;
        q_d = {q_q[DUTY_BITS-2:0], unit_carry};
        if (PERMILLE_FULL[idx_q]) begin
          state_d = D_ADD;
        end else if (idx_q == '0) begin
          state_d = D_RND;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      D_ADD: begin
        r_d = unit_sum;
        q_d = q_q + {{(DUTY_BITS-1){1'b0}}, unit_carry};
        if (idx_q == '0) begin
          state_d = D_RND;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = D_DBL;
        end
      end
      D_RND: begin
        // 2r >= period rounds half up
        if (q_round > {1'b0, PERMILLE_FULL}) begin
          duty_d = PERMILLE_FULL;
        end else begin
          duty_d = q_round[DUTY_BITS-1:0];
        end
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    h_q    <= h_d;
    p_q    <= p_d;
    q_q    <= q_d;
    idx_q  <= idx_d;
    duty_q <= duty_d;
  end

  assign done_o = done_q;
  assign duty_o = duty_q;

endmodule

// ===== rtl/pwm_duty_meter_with_enable.sv =====
// top level of the pwm duty meter with enable gating and on-time accumulation
// a pwm rising edge with a valid period runs the duty divider, one modular add per cycle;
// other events skip it; one event at a time, a new transfer is taken only in idle, and
// a held result on the output stalls the return to idle while m_axis_tready is low
// reset: asynchronous, clears the stored times, on-time total, duty, enable and output
// flags, sets pending and shown-active, sets timeout to 3000000 ns
module pwm_duty_meter_with_enable #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [55:0]                   s_axis_tdata,  // level, now_ns
  input  logic [pdm_pkg::OP_BITS-1:0]   s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,  // duty, lamp_active, active_time_ns
  output logic [0:0]                    m_axis_tuser,  // refresh
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [pdm_pkg::CFG_BITS-1:0]  pwdata,
  output logic [pdm_pkg::CFG_BITS-1:0]  prdata,
  output logic                          pready
);
  import pdm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_PWM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [OP_BITS-1:0]   op_q;
  logic                 level_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] since_rise_q;
  logic [TIME_BITS-1:0] since_tick_q;
  logic [TIME_BITS-1:0] since_edge_q;

  logic [CFG_BITS-1:0]  timeout_q;
  logic [TIME_BITS-1:0] last_rise_q;
  logic [TIME_BITS-1:0] last_high_q;
  logic [TIME_BITS-1:0] last_edge_q;
  logic [TIME_BITS-1:0] last_tick_q;
  logic [TIME_BITS-1:0] active_total_q;
  logic [DUTY_BITS-1:0] duty_q;
  logic                 enable_q;
  logic                 active_q;
  logic                 shown_active_q;
  logic [DUTY_BITS-1:0] shown_duty_q;
  logic                 pending_q;
  logic                 refresh_q;

  logic                 out_valid_q;
  logic [63:0]          out_data_q;
  logic                 out_user_q;

  logic                 in_xfer;
  logic                 cfg_write;
  logic                 rise_ok;
  logic [TIME_BITS-1:0] high_clamped;
  logic                 div_start;
  logic                 div_done;
  logic [DUTY_BITS-1:0] div_duty;
  logic                 timed_out;
  logic [DUTY_BITS-1:0] tick_duty;
  logic                 tick_active;
  logic                 tick_refresh;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign cfg_write = psel && penable && pwrite && pready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? '0 : timeout_q;

  assign rise_ok      = (last_rise_q != '0) && (since_rise_q != '0);
  assign high_clamped = (last_high_q > since_rise_q) ? since_rise_q : last_high_q;
  assign div_start    = (state_q == S_PWM) && level_q && rise_ok;

  pdm_duty_div #(
    .TIME_BITS(TIME_BITS)
  ) u_duty_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .high_i  (high_clamped),
    .period_i(since_rise_q),
    .done_o  (div_done),
    .duty_o  (div_duty)
  );

  assign timed_out    = (last_edge_q == '0) ||
                        (since_edge_q > TIME_BITS'(timeout_q));
  assign tick_duty    = timed_out ? '0 : duty_q;
  assign tick_active  = enable_q && (tick_duty != '0);
  assign tick_refresh = pending_q || (tick_duty != duty_q) || (tick_active != active_q) ||
                        (tick_active != shown_active_q) || (tick_duty != shown_duty_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        case (op_q)
          OP_PWM:  state_d = S_PWM;
          OP_TICK: state_d = S_TICK;
          default: state_d = S_OUT;
        endcase
      end
      S_PWM: begin
        state_d = div_start ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_TICK: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      timeout_q      <= TIMEOUT_RESET;
      last_rise_q    <= '0;
      last_high_q    <= '0;
      last_edge_q    <= '0;
      last_tick_q    <= '0;
      active_total_q <= '0;
      duty_q         <= '0;
      enable_q       <= 1'b0;
      active_q       <= 1'b0;
      shown_active_q <= 1'b1;
      shown_duty_q   <= '0;
      pending_q      <= 1'b1;
      refresh_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write && !paddr[2]) begin
        timeout_q <= pwdata;
      end
      if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          refresh_q <= 1'b0;
        end
        S_CALC: begin
          if (op_q == OP_ENABLE && level_q != enable_q) begin
            enable_q  <= level_q;
            pending_q <= 1'b1;
          end
        end
        S_PWM: begin
          last_edge_q <= now_q;
          if (level_q) begin
            last_rise_q <= now_q;
          end else if (rise_ok) begin
            last_high_q <= since_rise_q;
          end
        end
        S_DIV: begin
          if (div_done && div_duty != duty_q) begin
            duty_q    <= div_duty;
            pending_q <= 1'b1;
          end
        end
        S_TICK: begin
          if (last_tick_q != '0 && active_q) begin
            active_total_q <= active_total_q + since_tick_q;
          end
          last_tick_q <= now_q;
          duty_q      <= tick_duty;
          active_q    <= tick_active;
          if (tick_refresh) begin
            shown_active_q <= tick_active;
            shown_duty_q   <= tick_duty;
            pending_q      <= 1'b0;
            refresh_q      <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= s_axis_tuser;
      level_q <= s_axis_tdata[0];
      now_q   <= TIME_BITS'(s_axis_tdata[NOW_BITS:1]);
    end
    if (state_q == S_CALC) begin
      since_rise_q <= now_q - last_rise_q;
      since_tick_q <= now_q - last_tick_q;
      since_edge_q <= now_q - last_edge_q;
    end
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {5'd0, NOW_BITS'(active_total_q), active_q, duty_q};
      out_user_q <= refresh_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
